// File: rtl/bpcs_pkg.sv
// Shared types and codes for the buffer pool clock sweep block.
package bpcs_pkg;

	typedef logic [1:0] action_t;
	localparam action_t ACT_FETCH     = 2'd0;
	localparam action_t ACT_UNPIN     = 2'd1;
	localparam action_t ACT_FLUSH_ONE = 2'd2;
	localparam action_t ACT_FLUSH_ALL = 2'd3;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_HIT    = 3'd0;
	localparam kind_t KIND_MISS   = 3'd1;
	localparam kind_t KIND_WB     = 3'd2;
	localparam kind_t KIND_ACK    = 3'd3;
	localparam kind_t KIND_PINNED = 3'd4;

	localparam logic [7:0] PIN_MAX = 8'hFF;
	localparam logic [3:0] MAX_USAGE_RESET = 4'd5;

	typedef struct packed {
		action_t     action;
		logic [31:0] page_id;
		logic        mark_dirty;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  frame;
		logic [31:0] page_id_out;
		logic        last;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] eviction_count;
	} rsp_t;

	// One frame's entry in the frame store.
	typedef struct packed {
		logic [31:0] page;
		logic        dirty;
		logic [7:0]  pin;
		logic [3:0]  usage;
	} ent_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_HIT,
		WR_LOAD,
		WR_UNPIN,
		WR_CLEAN,
		WR_DECUSE
	} wr_op_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_INC,
		IDX_FREE,
		IDX_HAND
	} idx_op_t;

	typedef enum logic [1:0] {
		PG_REQ,
		PG_ENT,
		PG_ZERO
	} pg_src_t;

	typedef struct packed {
		logic    accept;
		logic    rd;
		idx_op_t idx_op;
		wr_op_t  wr_op;
		logic    note_free;
		logic    cnt_hit;
		logic    cnt_miss;
		logic    cnt_evict;
		logic    hand_set;
		logic    step_clr;
		logic    step_inc;
		logic    seen_set;
		logic    emit;
		kind_t   kind;
		logic    frame_zero;
		pg_src_t pg_src;
		logic    last;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    match;
		logic    ent_valid;
		logic    ent_dirty;
		logic    ent_pinned;
		logic    ent_used;
		logic    idx_last;
		logic    free_found;
		logic    steps_last;
		logic    seen;
		logic    can_emit;
	} sts_t;

endpackage

// File: rtl/bpcs_ctrl.sv
// Controller state machine that sequences lookups, sweeps and flushes.
module bpcs_ctrl import bpcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_RD     = 12'b000000000010,
		S_EV     = 12'b000000000100,
		S_ACK1   = 12'b000000001000,
		S_MISS   = 12'b000000010000,
		S_LOAD   = 12'b000000100000,
		S_SRD    = 12'b000001000000,
		S_SEV    = 12'b000010000000,
		S_SWB    = 12'b000100000000,
		S_PINNED = 12'b001000000000,
		S_WBALL  = 12'b010000000000,
		S_ACKALL = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					cmd.idx_op = IDX_CLR;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				if (sts.action == ACT_FLUSH_ALL) begin
					if (sts.ent_valid && sts.ent_dirty) begin
						state_d = S_WBALL;
					end else if (sts.idx_last) begin
						state_d = S_ACKALL;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d = S_RD;
					end
				end else if (sts.match) begin
					cmd.kind = KIND_ACK;
					cmd.pg_src = PG_REQ;
					cmd.last = 1'b1;
					if (sts.action == ACT_FETCH) begin
						cmd.kind = KIND_HIT;
						if (sts.can_emit) begin
							cmd.wr_op = WR_HIT;
							cmd.cnt_hit = 1'b1;
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end else if (sts.action == ACT_UNPIN) begin
						if (sts.can_emit) begin
							cmd.wr_op = WR_UNPIN;
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end else if (sts.ent_dirty) begin
						cmd.kind = KIND_WB;
						cmd.pg_src = PG_ENT;
						cmd.last = 1'b0;
						if (sts.can_emit) begin
							cmd.wr_op = WR_CLEAN;
							cmd.emit = 1'b1;
							state_d = S_ACK1;
						end
					end else if (sts.can_emit) begin
						cmd.emit = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.note_free = 1'b1;
					if (!sts.idx_last) begin
						cmd.idx_op = IDX_INC;
						state_d = S_RD;
					end else if (sts.action == ACT_FETCH) begin
						state_d = S_MISS;
					end else begin
						cmd.kind = KIND_ACK;
						cmd.frame_zero = 1'b1;
						cmd.pg_src = PG_REQ;
						cmd.last = 1'b1;
						if (sts.can_emit) begin
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end
				end
			end
			S_ACK1: begin
				cmd.kind = KIND_ACK;
				cmd.pg_src = PG_REQ;
				cmd.last = 1'b1;
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MISS: begin
				cmd.cnt_miss = 1'b1;
				if (sts.free_found) begin
					cmd.idx_op = IDX_FREE;
					state_d = S_LOAD;
				end else begin
					cmd.idx_op = IDX_HAND;
					cmd.step_clr = 1'b1;
					state_d = S_SRD;
				end
			end
			S_LOAD: begin
				cmd.kind = KIND_MISS;
				cmd.pg_src = PG_REQ;
				cmd.last = 1'b1;
				if (sts.can_emit) begin
					cmd.wr_op = WR_LOAD;
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SRD: begin
				cmd.rd = 1'b1;
				state_d = S_SEV;
			end
			S_SEV: begin
				if (sts.ent_pinned) begin
					if (sts.steps_last && !sts.seen) begin
						state_d = S_PINNED;
					end else begin
						cmd.idx_op = IDX_INC;
						cmd.step_inc = 1'b1;
						state_d = S_SRD;
					end
				end else if (sts.ent_used) begin
					cmd.wr_op = WR_DECUSE;
					cmd.seen_set = 1'b1;
					cmd.idx_op = IDX_INC;
					cmd.step_inc = 1'b1;
					state_d = S_SRD;
				end else begin
					// Victim found: the hand moves just past it.
					cmd.hand_set = 1'b1;
					cmd.cnt_evict = 1'b1;
					state_d = sts.ent_dirty ? S_SWB : S_LOAD;
				end
			end
			S_SWB: begin
				cmd.kind = KIND_WB;
				cmd.pg_src = PG_ENT;
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_PINNED: begin
				cmd.kind = KIND_PINNED;
				cmd.frame_zero = 1'b1;
				cmd.pg_src = PG_REQ;
				cmd.last = 1'b1;
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WBALL: begin
				cmd.kind = KIND_WB;
				cmd.pg_src = PG_ENT;
				if (sts.can_emit) begin
					cmd.wr_op = WR_CLEAN;
					cmd.emit = 1'b1;
					if (sts.idx_last) begin
						state_d = S_ACKALL;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d = S_RD;
					end
				end
			end
			S_ACKALL: begin
				cmd.kind = KIND_ACK;
				cmd.frame_zero = 1'b1;
				cmd.pg_src = PG_ZERO;
				cmd.last = 1'b1;
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/bpcs_dp.sv
// Datapath: frame store, valid bits, clock hand, counters and result register.
module bpcs_dp import bpcs_pkg::*; #(
	parameter int FRAME_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic       cfg_valid,
	input  logic [3:0] cfg_data,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp
);

	localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(FRAME_COUNT - 1);

	ent_t              mem [FRAME_COUNT];
	ent_t              ent_q;
	ent_t              wdata;
	logic              wr_en;
	req_t              req_q;
	logic [FRAME_COUNT-1:0] valid_q;
	logic [IW-1:0]     idx_q, idx_next;
	logic [IW-1:0]     hand_q, free_idx_q, steps_q;
	logic              free_found_q, seen_q;
	logic [31:0]       hits_q, misses_q, evict_q;
	logic [31:0]       hits_d, misses_d, evict_d;
	logic [3:0]        max_usage_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              ent_valid;

	assign idx_next = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
	assign ent_valid = valid_q[idx_q];

	always_comb begin
		wdata = ent_q;
		wr_en = 1'b1;
		unique case (cmd.wr_op)
			WR_HIT: begin
				if (ent_q.pin != PIN_MAX) wdata.pin = ent_q.pin + 1'b1;
				if (ent_q.usage < max_usage_q) wdata.usage = ent_q.usage + 1'b1;
			end
			WR_LOAD: begin
				wdata.page = req_q.page_id;
				wdata.dirty = 1'b0;
				wdata.pin = 8'd1;
				wdata.usage = 4'd1;
			end
			WR_UNPIN: begin
				wdata.dirty = ent_q.dirty | req_q.mark_dirty;
				if (ent_q.pin != '0) wdata.pin = ent_q.pin - 1'b1;
			end
			WR_CLEAN: begin
				wdata.dirty = 1'b0;
			end
			WR_DECUSE: begin
				wdata.usage = ent_q.usage - 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[idx_q] <= wdata;
		if (cmd.rd) ent_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req;
	end

	assign hits_d   = hits_q + 32'(cmd.cnt_hit);
	assign misses_d = misses_q + 32'(cmd.cnt_miss);
	assign evict_d  = evict_q + 32'(cmd.cnt_evict);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
			hand_q <= '0;
			free_idx_q <= '0;
			free_found_q <= 1'b0;
			steps_q <= '0;
			seen_q <= 1'b0;
			hits_q <= '0;
			misses_q <= '0;
			evict_q <= '0;
			max_usage_q <= MAX_USAGE_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			hits_q <= hits_d;
			misses_q <= misses_d;
			evict_q <= evict_d;
			if (cfg_valid) max_usage_q <= cfg_data;
			if (cmd.wr_op == WR_LOAD) valid_q[idx_q] <= 1'b1;
			if (cmd.accept) free_found_q <= 1'b0;
			if (cmd.note_free && !ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (cmd.hand_set) hand_q <= idx_next;
			if (cmd.step_clr) begin
				steps_q <= '0;
				seen_q <= 1'b0;
			end else begin
				if (cmd.step_inc) steps_q <= steps_q + 1'b1;
				if (cmd.seen_set) seen_q <= 1'b1;
			end
			unique case (cmd.idx_op)
				IDX_CLR:  idx_q <= '0;
				IDX_INC:  idx_q <= idx_next;
				IDX_FREE: idx_q <= free_idx_q;
				IDX_HAND: idx_q <= hand_q;
				default:  idx_q <= idx_q;
			endcase
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result beat payload; it holds while the beat is stalled.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.kind <= cmd.kind;
			rsp_q.frame <= cmd.frame_zero ? 4'd0 : 4'(idx_q);
			unique case (cmd.pg_src)
				PG_REQ:  rsp_q.page_id_out <= req_q.page_id;
				PG_ENT:  rsp_q.page_id_out <= ent_q.page;
				default: rsp_q.page_id_out <= '0;
			endcase
			rsp_q.last <= cmd.last;
			rsp_q.hit_count <= hits_d;
			rsp_q.miss_count <= misses_d;
			rsp_q.eviction_count <= evict_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		sts.action = req_q.action;
		sts.ent_valid = ent_valid;
		sts.match = ent_valid && (ent_q.page == req_q.page_id);
		sts.ent_dirty = ent_q.dirty;
		sts.ent_pinned = (ent_q.pin != '0);
		sts.ent_used = (ent_q.usage != '0);
		sts.idx_last = (idx_q == IDX_LAST);
		sts.free_found = free_found_q;
		sts.steps_last = (steps_q == IDX_LAST);
		sts.seen = seen_q;
		sts.can_emit = !rsp_valid_q || !rsp_stall;
	end

endmodule

// File: rtl/buffer_pool_clock_sweep.sv
// Buffer pool frame manager with clock sweep replacement, one request at a time.
// Each request scans the frame store frame by frame: read a frame, then evaluate it.
// A fetch hit stops at the matching frame; a miss scans every frame, then sweeps from
// the hand unless a free frame was found and writes back a dirty victim. Flush all
// scans every frame and writes back each dirty one; beats wait on stall.
// Reset clears control, valid bits, counters and the hand; no clearing pass is run.
module buffer_pool_clock_sweep import bpcs_pkg::*; #(
	parameter int FRAME_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bpcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpcs_dp #(
		.FRAME_COUNT (FRAME_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
